/* src/usgsp_pkg.sv */
// ----------------------------------------------------------------------------
// usgsp_pkg
// Shared constants for the upsampling-gradient sum pool: register map,
// register widths and reset values, fixed plane limits.
// ----------------------------------------------------------------------------
package usgsp_pkg;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_SCALE        = 2'd0,
        REG_SMALL_WIDTH  = 2'd1,
        REG_SMALL_HEIGHT = 2'd2
    } reg_idx_t;

    // register field widths
    localparam int SCALE_REG_W  = 4;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;

    // register reset values
    localparam logic [SCALE_REG_W-1:0]  SCALE_RST  = 4'd2;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd64;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd64;

    // reduced plane height limit and row counter width
    localparam int MAX_SMALL_HEIGHT = 4096;
    localparam int ROW_W            = 12;
    localparam int HGT_W            = 13;

    // result queue depth
    localparam int OUT_QUEUE_DEPTH = 4;

endpackage

/* src/usgsp_if.sv */
// ----------------------------------------------------------------------------
// usgsp channel interfaces
// Valid/ready channels for incoming gradient samples and pooled sums.
// ----------------------------------------------------------------------------
interface usgsp_sample_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] grad_sample;

    modport source (output valid, output grad_sample, input ready);
    modport sink   (input valid, input grad_sample, output ready);
endinterface

interface usgsp_sum_if #(parameter int SUM_BITS = 22);
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] pooled_sum;
    logic                       end_of_row;
    logic                       end_of_plane;

    modport source (output valid, output pooled_sum, output end_of_row,
                    output end_of_plane, input ready);
    modport sink   (input valid, input pooled_sum, input end_of_row,
                    input end_of_plane, output ready);
endinterface

/* src/usgsp_out_queue.sv */
// ----------------------------------------------------------------------------
// usgsp_out_queue
// Small FIFO that decouples finished window sums from the output channel.
// ----------------------------------------------------------------------------
module usgsp_out_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic                         not_empty,
    output logic [WIDTH-1:0]             head_data,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import usgsp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (32'(p) == DEPTH - 1)
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_data;
    end

    assign not_empty = (count_reg != '0);
    assign head_data = entry_mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

/* src/upsample_gradient_sum_pool.sv */
// ----------------------------------------------------------------------------
// upsample_gradient_sum_pool
// Backward pass of nearest-neighbor 2D upsampling: sums each scale x scale
// window of the incoming gradient plane into one reduced-plane value.
// ----------------------------------------------------------------------------
// Takes one gradient sample per clock (Q8.8, raster order of the upsampled
// plane) and returns one Q14.8 sum per scale x scale window, flagged with
// end_of_row / end_of_plane; planes simply follow one another. After its last
// sample is taken, the sum of a window passes the stage-1 registers and the
// result queue before it is offered on the output channel. Throughput is one
// sample per cycle, set by the single column memory (one read and one write
// port) that holds partial window sums for the current band of rows. Samples
// of a window row are added in a register first; the memory sees one
// read-modify-write per window row, and when scale is above one a column is
// written back before it is read again (at scale one every access starts its
// column fresh), so no forwarding is needed. Finished sums sit in a four-entry
// queue; input stalls only when that queue backs up.
// Registers: 0x0 scale, 0x4 small_width, 0x8 small_height. Zero acts as 1,
// larger values clamp to the build limits. Any write to these restarts the plane and
// must only be done while the block is idle.
module upsample_gradient_sum_pool #(
    parameter int MAX_SMALL_WIDTH = 1024,
    parameter int MAX_SCALE       = 8,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB config
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [usgsp_pkg::PADDR_W-1:0]   paddr,
    input  logic [usgsp_pkg::PDATA_W-1:0]   pwdata,
    output logic [usgsp_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,
    // streams
    usgsp_sample_if.sink                    samples,
    usgsp_sum_if.source                     sums
);
    import usgsp_pkg::*;

    // sum grows by log2(scale^2) bits over a sample
    localparam int SUM_W   = SAMPLE_BITS + 2 * $clog2(MAX_SCALE);
    localparam int SUB_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int SCL_W   = $clog2(MAX_SCALE + 1);
    localparam int COL_W   = (MAX_SMALL_WIDTH > 1) ? $clog2(MAX_SMALL_WIDTH) : 1;
    localparam int WID_W   = $clog2(MAX_SMALL_WIDTH + 1);
    localparam int RES_W   = SUM_W + 2;
    localparam int QCNT_W  = $clog2(OUT_QUEUE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [SCALE_REG_W-1:0]  scale_reg;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic                    cfg_wr;
    logic                    cfg_restart;
    reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SCALE:        scale_reg  <= pwdata[SCALE_REG_W-1:0];
                REG_SMALL_WIDTH:  width_reg  <= pwdata[WIDTH_REG_W-1:0];
                REG_SMALL_HEIGHT: height_reg <= pwdata[HEIGHT_REG_W-1:0];
                default:          ;
            endcase
        end
    end

    // a write to a known register restarts the plane
    always_comb
    begin
        cfg_restart = 1'b0;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SCALE, REG_SMALL_WIDTH, REG_SMALL_HEIGHT: cfg_restart = 1'b1;
                default:                                      cfg_restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SCALE:        prdata = PDATA_W'(scale_reg);
            REG_SMALL_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_SMALL_HEIGHT: prdata = PDATA_W'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // effective geometry: zero means one, clamp to build limits
    logic [SCL_W-1:0] scale_eff;
    logic [WID_W-1:0] width_eff;
    logic [HGT_W-1:0] height_eff;

    always_comb
    begin
        if (scale_reg == '0)
            scale_eff = SCL_W'(1);
        else if (32'(scale_reg) > MAX_SCALE)
            scale_eff = SCL_W'(MAX_SCALE);
        else
            scale_eff = SCL_W'(scale_reg);

        if (width_reg == '0)
            width_eff = WID_W'(1);
        else if (32'(width_reg) > MAX_SMALL_WIDTH)
            width_eff = WID_W'(MAX_SMALL_WIDTH);
        else
            width_eff = WID_W'(width_reg);

        if (height_reg == '0)
            height_eff = HGT_W'(1);
        else if (32'(height_reg) > MAX_SMALL_HEIGHT)
            height_eff = HGT_W'(MAX_SMALL_HEIGHT);
        else
            height_eff = height_reg;
    end

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    logic [SUB_W-1:0] sub_col_reg, sub_col_next;
    logic [SUB_W-1:0] sub_row_reg, sub_row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             last_sc, last_sr, last_col, last_row;
    logic             accept;
    logic             s1_out;
    logic [QCNT_W-1:0] q_count;

    assign last_sc  = (SCL_W'(sub_col_reg) == scale_eff - SCL_W'(1));
    assign last_sr  = (SCL_W'(sub_row_reg) == scale_eff - SCL_W'(1));
    assign last_col = (WID_W'(col_reg) == width_eff - WID_W'(1));
    assign last_row = (HGT_W'(row_reg) == height_eff - HGT_W'(1));

    // room for every sum that may still come out of the pipe
    assign samples.ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_out))
                           < (QCNT_W + 1)'(OUT_QUEUE_DEPTH);
    assign accept = samples.valid & samples.ready;

    always_comb
    begin
        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        if (cfg_restart)
        begin
            sub_col_next = '0;
            sub_row_next = '0;
            col_next     = '0;
            row_next     = '0;
        end
        else if (accept)
        begin
            if (!last_sc)
                sub_col_next = sub_col_reg + SUB_W'(1);
            else
            begin
                sub_col_next = '0;
                if (!last_col)
                    col_next = col_reg + COL_W'(1);
                else
                begin
                    col_next = '0;
                    if (!last_sr)
                        sub_row_next = sub_row_reg + SUB_W'(1);
                    else
                    begin
                        sub_row_next = '0;
                        row_next     = last_row ? '0 : row_reg + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Horizontal pre-sum over one window row
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [SUM_W-1:0] seg_sum;
    logic signed [SUM_W-1:0] hacc_reg;

    assign sample_ext = {{(SUM_W - SAMPLE_BITS){samples.grad_sample[SAMPLE_BITS-1]}},
                         samples.grad_sample};
    assign seg_sum    = (sub_col_reg == '0) ? sample_ext : hacc_reg + sample_ext;

    always_ff @(posedge clk)
    begin
        if (accept)
            hacc_reg <= seg_sum;
    end

    // ------------------------------------------------------------------
    // Stage 1: window row done, column memory read in flight
    // ------------------------------------------------------------------
    logic                    seg_done;
    logic                    s1_valid_reg;
    logic signed [SUM_W-1:0] s1_seg_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_first_reg;
    logic                    s1_last_reg;
    logic                    s1_eor_reg;
    logic                    s1_eop_reg;

    assign seg_done = accept & last_sc;
    assign s1_out   = s1_valid_reg & s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= seg_done;
    end

    always_ff @(posedge clk)
    begin
        if (seg_done)
        begin
            s1_seg_reg   <= seg_sum;
            s1_col_reg   <= col_reg;
            s1_first_reg <= (sub_row_reg == '0);
            s1_last_reg  <= last_sr;
            s1_eor_reg   <= last_col;
            s1_eop_reg   <= last_col & last_row;
        end
    end

    // ------------------------------------------------------------------
    // Column sum memory: read at stage 0, write back at stage 1
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] col_mem [MAX_SMALL_WIDTH];
    logic signed [SUM_W-1:0] mem_rdata_reg;
    logic signed [SUM_W-1:0] win_sum;

    always_ff @(posedge clk)
    begin
        if (seg_done)
            mem_rdata_reg <= col_mem[col_reg];
    end

    // first window row starts the column fresh; stale data is ignored
    assign win_sum = s1_first_reg ? s1_seg_reg : mem_rdata_reg + s1_seg_reg;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            col_mem[s1_col_reg] <= win_sum;
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [RES_W-1:0] q_head;
    logic             sum_xfer;

    assign sum_xfer = sums.valid & sums.ready;

    usgsp_out_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_out),
        .push_data ({win_sum, s1_eor_reg, s1_eop_reg}),
        .pop       (sum_xfer),
        .not_empty (sums.valid),
        .head_data (q_head),
        .count     (q_count)
    );

    assign sums.pooled_sum   = q_head[RES_W-1:2];
    assign sums.end_of_row   = q_head[1];
    assign sums.end_of_plane = q_head[0];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // queue never takes a sum it has no room for
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_out |-> (q_count < QCNT_W'(OUT_QUEUE_DEPTH)) || sum_xfer)
        else $error("result queue overflow");

    // back-to-back memory access to one column only when the newer one restarts it
    a_no_rmw_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_done && s1_valid_reg && (s1_col_reg == col_reg)) |-> (sub_row_reg == '0))
        else $error("column read overlaps pending write");

    // window position stays inside the scale
    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (SCL_W'(sub_col_reg) < scale_eff) && (SCL_W'(sub_row_reg) < scale_eff))
        else $error("window position out of range");

    // plane end only on a row end
    a_eop_on_eor: assert property (@(posedge clk) disable iff (!rst_n)
        s1_out |-> (!s1_eop_reg || s1_eor_reg))
        else $error("end of plane without end of row");

    // stage 1 holds a window row in the cycle after that row completes
    a_stage_timing: assert property (@(posedge clk) disable iff (!rst_n)
        seg_done |=> s1_valid_reg)
        else $error("stage 1 lost a window row");

endmodule
